[hw/rtl/msud_pkg.sv]
// ============================================================================
// msud_pkg - shared types and constants of the minimal-standard uniform draw
// Holds the generator constants, the channel payloads and the job record
// that travels from the front part through the queue to the back part.
// ============================================================================
package msud_pkg;

  localparam int SEED_W = 31;
  localparam int DATA_W = 32;
  localparam int MULT_W = 15;

  localparam logic [MULT_W-1:0] LCG_MULT         = 15'd16807;
  localparam logic [SEED_W-1:0] LCG_MOD          = 31'h7FFF_FFFF;
  localparam logic [SEED_W-1:0] START_SEED_RESET = 31'd123456789;

  // Default depth of the queue between the front and back parts (two or more).
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic CMD_INT  = 1'b0;
  localparam logic CMD_FRAC = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic signed [DATA_W-1:0] low_bound;
    logic signed [DATA_W-1:0] high_bound;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] draw_value;
    logic [SEED_W-1:0]        seed_after;
    logic                     seed_error;
  } out_item_t;

  typedef logic [SEED_W-1:0] cfg_item_t;

  // One classified request: ordered bounds, span and the advanced seed.
  typedef struct packed {
    logic                     cmd;
    logic signed [DATA_W-1:0] lo;
    logic [DATA_W-1:0]        span;
    logic [SEED_W-1:0]        seed;
    logic                     err;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[hw/rtl/msud_stream_if.sv]
// ============================================================================
// msud_stream_if - valid/ready channel
// Carries one payload of type T per transfer; used for all three channels.
// ============================================================================
interface msud_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/minimal_standard_uniform_draw.sv]
// ============================================================================
// minimal_standard_uniform_draw - Lehmer generator with range mapping
// Draws integers or Q16.16 fractions uniformly between two bounds.
// ============================================================================
//
//   channel  dir  payload                                   transfer when
//   in_ch    in   cmd, low_bound, high_bound                valid && ready
//   out_ch   out  draw_value, seed_after, seed_error        valid && ready
//   cfg_ch   in   start_seed (31 bit)                       valid && ready
//
// The front part takes one request per cycle while the queue has room; the
// seed recurrence completes in that same cycle. The back part works through
// each request in order (queue pop, seed-by-span multiply, round and clamp)
// and takes no new job until the last is done, so it sets the sustained rate.
// Reset is synchronous and active low; it loads the seed with 123456789 and
// empties the queue and the result register. A stalled output holds its
// result while the front part keeps filling the queue.
//
module minimal_standard_uniform_draw import msud_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  msud_stream_if.sink   in_ch,
  msud_stream_if.sink   cfg_ch,
  msud_stream_if.source out_ch
);

  // Jobs leave the front part already classified: bounds in order, span
  // computed and the seed advanced, so the back part never sees raw inputs.
  logic    push_valid, push_ready;
  job_t    push_data;
  logic    pop_valid, pop_ready;
  job_t    pop_data;
  q_stat_t q_stat;

  msud_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  msud_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready),
    .stat       (q_stat)
  );

  // The back part pops one job, multiplies, then writes the result register.
  msud_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

  // A zero-seed result must carry a zero value and a zero seed.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.payload.seed_error) |->
      (out_ch.payload.draw_value == '0 && out_ch.payload.seed_after == '0))
    else $error("seed error result with nonzero fields");

  // The queue can never report full and empty at once.
  a_q_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

  // A pop of the queue happens only while it holds a job.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |-> !q_stat.empty)
    else $error("pop from empty queue");

  // With a queue depth of one, a push into the empty queue with no pop leaves the input stalled next cycle.
  a_fill_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && push_ready && !(pop_valid && pop_ready) && q_stat.empty &&
     QUEUE_DEPTH == 1) |=> !in_ch.ready)
    else $error("input not stalled on full queue");

endmodule

[hw/rtl/msud_front.sv]
// ============================================================================
// msud_front - request intake and seed recurrence
// Accepts requests, advances the seed, orders the bounds and pushes a job.
// ============================================================================
module msud_front import msud_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  msud_stream_if.sink          in_ch,
  msud_stream_if.sink          cfg_ch,
  output logic                 push_valid,
  output job_t                 push_data,
  input  logic                 push_ready
);

  localparam int PROD_W = SEED_W + MULT_W;

  logic [SEED_W-1:0]   seed_r, seed_nxt;
  logic [PROD_W-1:0]   prod;
  logic [SEED_W:0]     fold;
  logic [SEED_W-1:0]   stepped;
  logic                accept;
  logic                zero_seed;
  logic                swap;
  logic signed [DATA_W-1:0] lo, hi;
  logic signed [DATA_W:0]   diff;

  assign in_ch.ready  = push_ready;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && push_ready;

  // Mersenne reduction: fold the high bits onto the low bits, then one subtract.
  always_comb begin
    prod      = PROD_W'(seed_r) * PROD_W'(LCG_MULT);
    fold      = {1'b0, prod[SEED_W-1:0]} + (SEED_W+1)'(prod[PROD_W-1:SEED_W]);
    stepped   = (fold >= {1'b0, LCG_MOD}) ? SEED_W'(fold - {1'b0, LCG_MOD})
                                          : fold[SEED_W-1:0];
    zero_seed = (seed_r == '0);
  end

  always_comb begin
    swap = (in_ch.payload.high_bound < in_ch.payload.low_bound);
    lo   = swap ? in_ch.payload.high_bound : in_ch.payload.low_bound;
    hi   = swap ? in_ch.payload.low_bound  : in_ch.payload.high_bound;
    diff = {hi[DATA_W-1], hi} - {lo[DATA_W-1], lo};
  end

  always_comb begin
    push_valid     = in_ch.valid;
    push_data.cmd  = in_ch.payload.cmd;
    push_data.lo   = lo;
    push_data.span = diff[DATA_W-1:0];
    push_data.seed = zero_seed ? '0 : stepped;
    push_data.err  = zero_seed;
  end

  always_comb begin
    seed_nxt = seed_r;
    if (cfg_ch.valid) begin
      seed_nxt = cfg_ch.payload;
    end else if (accept && !zero_seed) begin
      seed_nxt = stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= START_SEED_RESET;
    end else begin
      seed_r <= seed_nxt;
    end
  end

endmodule

[hw/rtl/msud_queue.sv]
// ============================================================================
// msud_queue - short job queue
// Register-based FIFO between the front and back parts.
// ============================================================================
module msud_queue import msud_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  input  job_t    push_data,
  output logic    push_ready,
  output logic    pop_valid,
  output job_t    pop_data,
  input  logic    pop_ready,
  output q_stat_t stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign push_ready = !stat.full;
  assign pop_valid  = !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hw/rtl/msud_back.sv]
// ============================================================================
// msud_back - range mapping and result register
// Multiplies seed by span, then rounds or truncates onto the range.
// ============================================================================
module msud_back import msud_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         pop_valid,
  input  job_t         pop_data,
  output logic         pop_ready,
  msud_stream_if.source out_ch
);

  localparam int PROD_W = SEED_W + DATA_W;
  localparam int BASE_W = DATA_W + 2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  job_t              job_r;
  logic [PROD_W-1:0] prod_r;
  out_item_t         out_r, result;
  logic              out_valid_r, out_valid_nxt;
  logic              load_out;

  logic [PROD_W-1:0]        x;
  logic [DATA_W-1:0]        q;
  logic signed [BASE_W-1:0] lo_ext, base, adj;

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;
  assign pop_ready      = (state_r == ST_IDLE);
  assign load_out       = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  // The integer draw uses seed*(span+1); the fraction draw seed*span.
  // In the integer draw, an exact step (fraction bits zero) at or below zero
  // is taken one lower, then clamped back to the low bound.
  always_comb begin
    x      = prod_r + ((job_r.cmd == CMD_INT) ? PROD_W'(job_r.seed) : '0);
    q      = x[PROD_W-1:SEED_W];
    lo_ext = $signed({{2{job_r.lo[DATA_W-1]}}, job_r.lo});
    base   = lo_ext + $signed({2'b00, q});
    adj    = base;
    if ((x[SEED_W-1:0] == '0) && (base <= 0)) begin
      adj = base - 1;
    end
    if (adj < lo_ext) begin
      adj = lo_ext;
    end
    result.seed_after = job_r.seed;
    result.seed_error = job_r.err;
    if (job_r.err) begin
      result.draw_value = '0;
    end else if (job_r.cmd == CMD_INT) begin
      result.draw_value = adj[DATA_W-1:0];
    end else begin
      result.draw_value = base[DATA_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (load_out) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      job_r <= pop_data;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(job_r.seed) * PROD_W'(job_r.span);
    end
    if (load_out) begin
      out_r <= result;
    end
  end

endmodule
